// ----- design/strq_pkg.sv -----
// shared types, codes and field widths for the segment tree range query block
package strq_pkg;

	localparam int MAX_ELEMENTS_DEF = 1024;
	localparam int VALUE_BITS_DEF = 32;

	localparam int MODE_W = 2;
	localparam int IDX_FIELD_W = 10;
	localparam int VAL_FIELD_W = 32;
	localparam int OP_FIELD_W = 2;
	localparam int SIZE_FIELD_W = 11;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [SIZE_FIELD_W-1:0] SIZE_RESET = SIZE_FIELD_W'(1024);

	typedef enum logic [MODE_W-1:0] {
		MODE_SET,
		MODE_MERGE,
		MODE_ADD,
		MODE_QUERY
	} mode_t;

	typedef enum logic [OP_FIELD_W-1:0] {
		CMB_SUM,
		CMB_MIN,
		CMB_MAX
	} combine_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COMBINE_OP,
		CFG_IDENTITY,
		CFG_SIZE
	} cfg_idx_t;

	typedef struct packed {
		mode_t                          mode;
		logic [IDX_FIELD_W-1:0]         index_low;
		logic [IDX_FIELD_W-1:0]         index_high;
		logic signed [VAL_FIELD_W-1:0]  value;
	} in_t;

	typedef struct packed {
		logic signed [VAL_FIELD_W-1:0]  result;
		logic                           status;
	} out_t;

	// datapath action issued by the controller each cycle
	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_CLR_RST,
		ACT_CLR,
		ACT_LOAD,
		ACT_DESC,
		ACT_LEAF_RD,
		ACT_LEAF_WR,
		ACT_SIB_RD,
		ACT_PAR_WR,
		ACT_POP,
		ACT_ACC,
		ACT_FINISH
	} act_t;

	typedef struct packed {
		logic clr_last;
		logic bad;
		logic query;
		logic empty;
		logic at_leaf;
		logic at_root;
		logic par_root;
		logic stk_empty;
		logic top_in;
	} stat_t;

endpackage

// ----- design/strq_ctrl.sv -----
// controller state machine sequencing clear, update and query walks
module strq_ctrl import strq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  refill,
	input  stat_t stat,
	output act_t  act,
	output logic  busy
);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_DESC,
		ST_LEAF_WR,
		ST_SIB_RD,
		ST_PAR_WR,
		ST_POP,
		ST_ACC,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   pend_q;

	assign busy = (state_q != ST_IDLE) || pend_q;

	always_comb begin
		act = ACT_NONE;
		case (state_q)
			ST_IDLE: begin
				if (start && !busy) begin
					act = ACT_LOAD;
				end else if (refill) begin
					act = ACT_CLR_RST;
				end else if (pend_q) begin
					act = ACT_CLR_RST;
				end
			end
			ST_CLEAR:   act = ACT_CLR;
			ST_DESC:    act = stat.at_leaf ? ACT_LEAF_RD : ACT_DESC;
			ST_LEAF_WR: act = ACT_LEAF_WR;
			ST_SIB_RD:  act = ACT_SIB_RD;
			ST_PAR_WR:  act = ACT_PAR_WR;
			ST_POP:     act = stat.stk_empty ? ACT_NONE : ACT_POP;
			ST_ACC:     act = ACT_ACC;
			ST_DONE:    act = ACT_FINISH;
			default:    act = ACT_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			pend_q  <= 1'b0;
		end else begin
			pend_q <= pend_q || refill;
			case (state_q)
				ST_IDLE: begin
					if (start && !busy) begin
						state_q <= ST_CHECK;
					end else if (refill || pend_q) begin
						state_q <= ST_CLEAR;
						pend_q  <= 1'b0;
					end
				end
				ST_CLEAR: begin
					if (stat.clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CHECK: begin
					if (stat.bad) begin
						state_q <= ST_DONE;
					end else if (stat.query) begin
						state_q <= stat.empty ? ST_DONE : ST_POP;
					end else begin
						state_q <= ST_DESC;
					end
				end
				ST_DESC: begin
					if (stat.at_leaf) begin
						state_q <= ST_LEAF_WR;
					end
				end
				ST_LEAF_WR: state_q <= stat.at_root ? ST_DONE : ST_SIB_RD;
				ST_SIB_RD:  state_q <= ST_PAR_WR;
				ST_PAR_WR:  state_q <= stat.par_root ? ST_DONE : ST_SIB_RD;
				ST_POP: begin
					if (stat.stk_empty) begin
						state_q <= ST_DONE;
					end else if (stat.top_in) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC:  state_q <= ST_POP;
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- design/strq_dp.sv -----
// datapath: node memory, walk registers, query stack and accumulator
module strq_dp import strq_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  act_t                      act,
	output stat_t                     stat,
	input  in_t                       req,
	input  logic [OP_FIELD_W-1:0]     combine_op,
	input  logic [VAL_FIELD_W-1:0]    identity,
	input  logic [$clog2(MAX_ELEMENTS)-1:0] n_m1,
	output logic                      done,
	output out_t                      rsp
);

	localparam int IDX_W = $clog2(MAX_ELEMENTS);
	localparam int NODES = 4 * MAX_ELEMENTS;
	localparam int AW = $clog2(NODES);
	localparam int VB = VALUE_BITS;
	localparam int SD = IDX_W + 2;
	localparam int SP_W = $clog2(SD + 1);
	localparam int SI_W = $clog2(SD);

	typedef struct packed {
		logic [AW-1:0]    node;
		logic [IDX_W-1:0] lo;
		logic [IDX_W-1:0] hi;
	} frame_t;

	function automatic logic [VB-1:0] widen(input logic [VAL_FIELD_W-1:0] x);
		logic [63:0] w;
		w = {{(64-VAL_FIELD_W){x[VAL_FIELD_W-1]}}, x};
		return w[VB-1:0];
	endfunction

	function automatic logic [VAL_FIELD_W-1:0] narrow(input logic [VB-1:0] v);
		logic [63:0] w;
		w = '0;
		w[VB-1:0] = v;
		return w[VAL_FIELD_W-1:0];
	endfunction

	function automatic logic [VB-1:0] merge_f(input logic [VB-1:0] a, input logic [VB-1:0] b,
			input logic [OP_FIELD_W-1:0] op);
		logic [VB-1:0] r;
		case (op)
			CMB_MIN: r = ($signed(a) <= $signed(b)) ? a : b;
			CMB_MAX: r = ($signed(a) >= $signed(b)) ? a : b;
			default: r = a + b;
		endcase
		return r;
	endfunction

	logic [VB-1:0]    mem [NODES];
	logic [VB-1:0]    rd_q;
	logic             mem_we;
	logic [AW-1:0]    mem_addr;
	logic [VB-1:0]    mem_wdata;

	mode_t            mode_q;
	logic [VB-1:0]    val_q;
	logic [IDX_W-1:0] lo_q;
	logic [IDX_W-1:0] hi_q;
	logic             bad_q;
	logic             empty_q;
	logic [AW-1:0]    node_q;
	logic [IDX_W-1:0] l_q;
	logic [IDX_W-1:0] r_q;
	logic [VB-1:0]    cur_q;
	frame_t           stk_q [SD];
	logic [SP_W-1:0]  sp_q;
	logic [VB-1:0]    acc_q;
	logic             acc_vld_q;
	logic [AW-1:0]    clr_addr_q;
	logic             done_q;
	out_t             rsp_q;

	logic [VB-1:0]    id_v;
	logic [31:0]      lo_w;
	logic [31:0]      hi_w;
	logic [31:0]      nm_w;
	logic [31:0]      hi_cl;
	logic             ld_bad;
	logic             ld_empty;
	logic [IDX_W:0]   sum_d;
	logic [IDX_W-1:0] mid_d;
	logic             go_left;
	logic [SI_W-1:0]  top_idx;
	logic [SI_W-1:0]  push_idx;
	frame_t           top;
	logic [IDX_W:0]   sum_t;
	logic [IDX_W-1:0] mid_t;
	logic             t_dis;
	logic             t_in;
	logic [VB-1:0]    leaf_new;
	logic [VB-1:0]    par_new;

	assign id_v  = widen(identity);
	assign lo_w  = 32'(req.index_low);
	assign hi_w  = 32'(req.index_high);
	assign nm_w  = 32'(n_m1);
	assign hi_cl = (hi_w > nm_w) ? nm_w : hi_w;
	assign ld_bad = lo_w > nm_w;
	assign ld_empty = lo_w > hi_cl;

	// update descent: pick the child that holds the leaf
	assign sum_d   = {1'b0, l_q} + {1'b0, r_q};
	assign mid_d   = sum_d[IDX_W:1];
	assign go_left = lo_q <= mid_d;

	assign top_idx  = SI_W'(sp_q - SP_W'(1));
	assign push_idx = SI_W'(sp_q);
	assign top      = stk_q[top_idx];
	assign sum_t    = {1'b0, top.lo} + {1'b0, top.hi};
	assign mid_t    = sum_t[IDX_W:1];
	assign t_dis    = (top.lo > hi_q) || (top.hi < lo_q);
	assign t_in     = (top.lo >= lo_q) && (top.hi <= hi_q);

	always_comb begin
		case (mode_q)
			MODE_SET:   leaf_new = val_q;
			MODE_MERGE: leaf_new = merge_f(rd_q, val_q, combine_op);
			default:    leaf_new = rd_q + val_q;
		endcase
	end

	assign par_new = merge_f(cur_q, rd_q, combine_op);

	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = node_q;
		mem_wdata = leaf_new;
		case (act)
			ACT_CLR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_addr_q;
				mem_wdata = id_v;
			end
			ACT_LEAF_WR: mem_we = 1'b1;
			ACT_SIB_RD:  mem_addr = {node_q[AW-1:1], ~node_q[0]};
			ACT_PAR_WR: begin
				mem_we    = 1'b1;
				mem_addr  = {1'b0, node_q[AW-1:1]};
				mem_wdata = par_new;
			end
			ACT_POP:     mem_addr = top.node;
			default:     mem_addr = node_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rd_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			sp_q       <= '0;
			acc_vld_q  <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= (act == ACT_FINISH);
			case (act)
				ACT_CLR_RST: clr_addr_q <= '0;
				ACT_CLR:     clr_addr_q <= clr_addr_q + AW'(1);
				ACT_LOAD: begin
					sp_q      <= SP_W'(1);
					acc_vld_q <= 1'b0;
				end
				ACT_POP: begin
					acc_vld_q <= acc_vld_q || t_dis;
					// a straddling node is replaced by its two children
					sp_q <= (t_dis || t_in) ? sp_q - SP_W'(1) : sp_q + SP_W'(1);
				end
				ACT_ACC:     acc_vld_q <= 1'b1;
				default:     acc_vld_q <= acc_vld_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (act)
			ACT_LOAD: begin
				mode_q     <= req.mode;
				val_q      <= widen(req.value);
				lo_q       <= IDX_W'(lo_w);
				hi_q       <= IDX_W'(hi_cl);
				bad_q      <= ld_bad;
				empty_q    <= ld_empty;
				node_q     <= AW'(1);
				l_q        <= '0;
				r_q        <= n_m1;
				stk_q[0]   <= '{node: AW'(1), lo: '0, hi: n_m1};
			end
			ACT_DESC: begin
				if (go_left) begin
					node_q <= {node_q[AW-2:0], 1'b0};
					r_q    <= mid_d;
				end else begin
					node_q <= {node_q[AW-2:0], 1'b1};
					l_q    <= mid_d + IDX_W'(1);
				end
			end
			ACT_LEAF_WR: cur_q <= leaf_new;
			ACT_PAR_WR: begin
				cur_q  <= par_new;
				node_q <= {1'b0, node_q[AW-1:1]};
			end
			ACT_POP: begin
				if (t_dis) begin
					acc_q <= acc_vld_q ? merge_f(acc_q, id_v, combine_op) : id_v;
				end else if (!t_in) begin
					stk_q[top_idx]  <= '{node: {top.node[AW-2:0], 1'b1},
						lo: mid_t + IDX_W'(1), hi: top.hi};
					stk_q[push_idx] <= '{node: {top.node[AW-2:0], 1'b0},
						lo: top.lo, hi: mid_t};
				end
			end
			ACT_ACC: acc_q <= acc_vld_q ? merge_f(acc_q, rd_q, combine_op) : rd_q;
			ACT_FINISH: begin
				if (mode_q == MODE_QUERY) begin
					rsp_q.result <= narrow((bad_q || empty_q) ? id_v : acc_q);
				end else begin
					rsp_q.result <= '0;
				end
				rsp_q.status <= bad_q;
			end
			default: cur_q <= cur_q;
		endcase
	end

	assign stat.clr_last  = clr_addr_q == AW'(NODES - 1);
	assign stat.bad       = bad_q;
	assign stat.query     = mode_q == MODE_QUERY;
	assign stat.empty     = empty_q;
	assign stat.at_leaf   = l_q == r_q;
	assign stat.at_root   = node_q == AW'(1);
	assign stat.par_root  = node_q[AW-1:1] == (AW-1)'(1);
	assign stat.stk_empty = sp_q == '0;
	assign stat.top_in    = t_in;

	assign done = done_q;
	assign rsp  = rsp_q;

	a_stack_room: assert property (@(posedge clk) disable iff (!arst_n)
		(act == ACT_POP && !t_dis && !t_in) |-> (sp_q < SP_W'(SD)))
		else $error("query stack overflow");

	a_mem_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ({1'b0, mem_addr} < (AW+1)'(NODES)))
		else $error("node write beyond memory");

	a_acc_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(act == ACT_ACC) |-> ($past(act) == ACT_POP))
		else $error("accumulate without a node read");

	a_no_parent_of_root: assert property (@(posedge clk) disable iff (!arst_n)
		(act == ACT_PAR_WR) |-> (node_q != AW'(1)))
		else $error("ascent past the root");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe longer than one cycle");

endmodule

// ----- design/segment_tree_range_query.sv -----
// top level: config registers, controller and datapath of the segment tree
//
// Segment tree over up to MAX_ELEMENTS values with point update and range query.
// Request channel: drive req and raise start; the transaction is taken at an edge
// where start is high and busy is low. Every transaction gives one result: done is
// high for exactly one cycle with rsp, and the receiver cannot stall it.
// Config port: cfg_we, cfg_idx, cfg_data write combine_op (0), identity_value (1)
// or size_in_use (2); any such write refills the node memory.
// Node memory is one single-port RAM of 4*MAX_ELEMENTS words; every node access
// goes through its one port, which sets the speed. The steps are:
//   update: descent to the leaf, leaf read-modify-write, then a sibling
//   read and parent write per level up to the root
//   query: one stack pop per visited node and one more step per node used whole
//   out of range positions and empty queries go straight from the check to done
// done and the fall of busy come in the same cycle unless a refill is pending,
// so a new transaction may start right away. After reset and after each config
// write the block fills all 4*MAX_ELEMENTS nodes with the identity, one per cycle,
// with busy high; config writes are still taken during the fill.
module segment_tree_range_query import strq_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  in_t                   req,
	output logic                  done,
	output out_t                  rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = $clog2(MAX_ELEMENTS);

	logic [OP_FIELD_W-1:0]   combine_op_q;
	logic [VAL_FIELD_W-1:0]  identity_q;
	logic [SIZE_FIELD_W-1:0] size_q;
	logic                    refill;
	logic [31:0]             size_w;
	logic [31:0]             n_w;
	logic [IDX_W-1:0]        n_m1;
	act_t                    act;
	stat_t                   stat;

	assign refill = cfg_we && (cfg_idx == CFG_COMBINE_OP || cfg_idx == CFG_IDENTITY ||
		cfg_idx == CFG_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			combine_op_q <= CMB_SUM;
			identity_q   <= '0;
			size_q       <= SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_COMBINE_OP: combine_op_q <= cfg_data[OP_FIELD_W-1:0];
				CFG_IDENTITY:   identity_q   <= cfg_data[VAL_FIELD_W-1:0];
				CFG_SIZE:       size_q       <= cfg_data[SIZE_FIELD_W-1:0];
				default:        size_q       <= size_q;
			endcase
		end
	end

	// live element count: zero acts as one, oversize is capped
	always_comb begin
		size_w = 32'(size_q);
		if (size_w == '0) begin
			n_w = 32'd1;
		end else if (size_w > 32'(MAX_ELEMENTS)) begin
			n_w = 32'(MAX_ELEMENTS);
		end else begin
			n_w = size_w;
		end
	end

	assign n_m1 = IDX_W'(n_w - 32'd1);

	strq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.refill (refill),
		.stat   (stat),
		.act    (act),
		.busy   (busy)
	);

	strq_dp #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.VALUE_BITS   (VALUE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.act        (act),
		.stat       (stat),
		.req        (req),
		.combine_op (combine_op_q),
		.identity   (identity_q),
		.n_m1       (n_m1),
		.done       (done),
		.rsp        (rsp)
	);

endmodule
